FILE: design/utf8_sanitizer_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 sanitizer assertion macros
// Shared wrappers for the concurrent checks in the sanitizer's modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_ASSERT_SVH
`define UTF8_SANITIZER_ASSERT_SVH

// A property checked at every rising edge outside reset.
`define UTF8S_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// An implication checked in the same cycle.
`define UTF8S_ASSERT_IMPL(label, ante, cons, msg) \
    `UTF8S_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: design/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer package
// Byte constants, the command passed from classifier to expander, and the
// queue status group.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Replacement character U+FFFD, first byte at index 0.
    localparam logic [2:0][7:0] REPL_SEQ = {8'hBD, 8'hBF, 8'hEF};
    localparam logic [1:0] REPL_LAST_IDX = 2'd2;

    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] DEL_CHAR  = 8'h7F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] SURR_LEAD = 8'hED;
    localparam logic [7:0] E0_MIN    = 8'hA0;
    localparam logic [7:0] SURR_MAX  = 8'h9F;
    localparam logic [7:0] F0_MIN    = 8'h90;
    localparam logic [7:0] F4_MAX    = 8'h8F;

    // One input byte's worth of output: n_repl replacement characters
    // followed by n_lit literal bytes.
    typedef struct packed {
        logic [3:0][7:0] lits;
        logic [2:0]      n_lit;
        logic [2:0]      n_repl;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: design/utf8s_front.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer classifier
// Accepts input beats, tracks the pending multi-byte sequence and turns each
// byte into a command for the expander.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_assert.svh"

module utf8s_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,   // string_end
    input  utf8s_pkg::q_stat_t q_stat,
    output logic               push,
    output utf8s_pkg::cmd_t    push_cmd
);

    logic [7:0] lead_reg, lead_next;
    logic [1:0] need_reg, need_next;
    logic [1:0] seen_reg, seen_next;
    logic [7:0] cont_reg [3];

    logic       accept;
    logic       pending;
    logic       cont_ok;
    logic       cont_we;
    logic [2:0] seen_inc;
    logic       f_print, f_lead, f_start, f_repl;
    logic [1:0] f_need;
    utf8s_pkg::cmd_t cmd;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign pending  = (need_reg != 2'd0);
    assign seen_inc = {1'b0, seen_reg} + 3'd1;

    always_comb begin
        cont_ok = (s_tdata inside {[utf8s_pkg::CONT_LO:utf8s_pkg::CONT_HI]});
        // The second byte of some leads has a narrower range.
        if (seen_reg == 2'd0) begin
            if ((lead_reg == utf8s_pkg::LEAD3_LO && s_tdata < utf8s_pkg::E0_MIN) ||
                (lead_reg == utf8s_pkg::SURR_LEAD && s_tdata > utf8s_pkg::SURR_MAX) ||
                (lead_reg == utf8s_pkg::LEAD4_LO && s_tdata < utf8s_pkg::F0_MIN) ||
                (lead_reg == utf8s_pkg::LEAD4_HI && s_tdata > utf8s_pkg::F4_MAX)) begin
                cont_ok = 1'b0;
            end
        end
    end

    always_comb begin
        f_print = !s_tdata[7] && (s_tdata >= utf8s_pkg::PRINT_LO)
                  && (s_tdata != utf8s_pkg::DEL_CHAR);
        f_lead  = 1'b1;
        f_need  = 2'd0;
        if (s_tdata inside {[utf8s_pkg::LEAD2_LO:utf8s_pkg::LEAD2_HI]}) begin
            f_need = 2'd1;
        end else if (s_tdata inside {[utf8s_pkg::LEAD3_LO:utf8s_pkg::LEAD3_HI]}) begin
            f_need = 2'd2;
        end else if (s_tdata inside {[utf8s_pkg::LEAD4_LO:utf8s_pkg::LEAD4_HI]}) begin
            f_need = 2'd3;
        end else begin
            f_lead = 1'b0;
        end
        f_start = f_lead && !s_tlast;
        f_repl  = s_tdata[7] && !f_start;
    end

    always_comb begin
        cmd       = '0;
        lead_next = lead_reg;
        need_next = need_reg;
        seen_next = seen_reg;
        cont_we   = 1'b0;
        if (pending && cont_ok) begin
            cont_we = 1'b1;
            if (seen_inc == {1'b0, need_reg}) begin
                // Sequence complete: emit lead and all continuations.
                cmd.lits[0] = lead_reg;
                for (int k = 0; k < 3; k++) begin
                    cmd.lits[k + 1] = (2'(k) == seen_reg) ? s_tdata : cont_reg[k];
                end
                cmd.n_lit = {1'b0, need_reg} + 3'd1;
                need_next = 2'd0;
                seen_next = 2'd0;
            end else if (s_tlast) begin
                cmd.n_repl = seen_inc + 3'd1;
                need_next  = 2'd0;
                seen_next  = 2'd0;
            end else begin
                seen_next = seen_inc[1:0];
            end
        end else begin
            // Either nothing pending, or the pending sequence is replaced and
            // this byte is taken afresh.
            cmd.n_repl  = (pending ? ({1'b0, seen_reg} + 3'd1) : 3'd0) + {2'b0, f_repl};
            cmd.lits[0] = s_tdata;
            cmd.n_lit   = {2'b0, f_print};
            if (f_start) begin
                lead_next = s_tdata;
                need_next = f_need;
            end else begin
                need_next = 2'd0;
            end
            seen_next = 2'd0;
        end
    end

    assign push     = accept && (cmd.n_repl != 3'd0 || cmd.n_lit != 3'd0);
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg <= '0;
            need_reg <= '0;
            seen_reg <= '0;
        end else if (accept) begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && cont_we) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) == seen_reg) begin
                    cont_reg[k] <= s_tdata;
                end
            end
        end
    end

    `UTF8S_ASSERT_IMPL(a_seen_below_need, need_reg != 2'd0, seen_reg < need_reg,
        "Continuation count reached the sequence length while still pending.")
    `UTF8S_ASSERT_IMPL(a_idle_seen_zero, need_reg == 2'd0, seen_reg == 2'd0,
        "Continuation count is non-zero with no sequence pending.")

endmodule

FILE: design/utf8s_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer command queue
// Short register queue between the classifier and the expander.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_assert.svh"

module utf8s_queue #(
    parameter int DEPTH = utf8s_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  utf8s_pkg::cmd_t    push_cmd,
    input  logic               pop,
    output utf8s_pkg::cmd_t    head_cmd,
    output utf8s_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8s_pkg::cmd_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head_cmd     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `UTF8S_ASSERT_IMPL(a_no_overflow, push, !q_stat.full || pop,
        "Command pushed into a full queue.")

endmodule

FILE: design/utf8s_back.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer expander
// Walks the command at the head of the queue and sends one output beat per
// cycle while m_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_assert.svh"

module utf8s_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  utf8s_pkg::cmd_t    head_cmd,
    input  utf8s_pkg::q_stat_t q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_byte
    output logic               m_tlast    // run_last
);

    logic [2:0] rep_cnt_reg, rep_cnt_next;
    logic [1:0] sub_reg, sub_next;
    logic [1:0] lit_cnt_reg, lit_cnt_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic       load_en;
    logic       fire;
    logic       in_rep;
    logic       last_rep, last_lit, item_last;
    logic [7:0] cur_byte;

    assign load_en = !m_tvalid_reg || m_tready;
    assign fire    = load_en && !q_stat.empty;
    assign in_rep  = (rep_cnt_reg < head_cmd.n_repl);
    assign cur_byte = in_rep ? utf8s_pkg::REPL_SEQ[sub_reg] : head_cmd.lits[lit_cnt_reg];

    assign last_rep  = in_rep && (sub_reg == utf8s_pkg::REPL_LAST_IDX)
                       && (rep_cnt_reg == head_cmd.n_repl - 3'd1)
                       && (head_cmd.n_lit == 3'd0);
    assign last_lit  = !in_rep && ({1'b0, lit_cnt_reg} == head_cmd.n_lit - 3'd1);
    assign item_last = last_rep || last_lit;
    assign pop       = fire && item_last;

    always_comb begin
        rep_cnt_next  = rep_cnt_reg;
        sub_next      = sub_reg;
        lit_cnt_next  = lit_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load_en) begin
            m_tvalid_next = !q_stat.empty;
        end
        if (fire) begin
            if (item_last) begin
                rep_cnt_next = '0;
                sub_next     = '0;
                lit_cnt_next = '0;
            end else if (in_rep) begin
                if (sub_reg == utf8s_pkg::REPL_LAST_IDX) begin
                    sub_next     = '0;
                    rep_cnt_next = rep_cnt_reg + 3'd1;
                end else begin
                    sub_next = sub_reg + 2'd1;
                end
            end else begin
                lit_cnt_next = lit_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_cnt_reg  <= '0;
            sub_reg      <= '0;
            lit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rep_cnt_reg  <= rep_cnt_next;
            sub_reg      <= sub_next;
            lit_cnt_reg  <= lit_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= item_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `UTF8S_ASSERT_IMPL(a_head_has_work, !q_stat.empty,
        in_rep || ({1'b0, lit_cnt_reg} < head_cmd.n_lit),
        "Expander position ran past the end of the head command.")

endmodule

FILE: design/utf8_sanitizer.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer
// Strict UTF-8 validator that drops control characters and replaces broken
// sequences with U+FFFD.
// ----------------------------------------------------------------------------
// Input channel s_*: one raw byte per beat in s_tdata, s_tlast on the last
// byte of each string. Output channel m_*: one sanitised byte per beat in
// m_tdata, with m_tlast on the final output byte caused by an input byte.
// An input byte may produce no output (controls, DEL, a lead or continuation
// still waiting for the rest of its sequence) or a burst of up to twelve
// bytes when a sequence is replaced.
// The classifier takes one byte every cycle while its command queue (four
// entries by default) has room. The expander sends one output beat per cycle
// while m_tready is high, so the sustained rate is one input beat per cycle
// as long as each byte yields at most one output beat; longer bursts are
// limited by the single output port. Commands reach m_* through the queue
// and the output register. Reset clears the pending sequence, the queue
// and the output register. When the receiver holds m_tready low, the output
// register keeps its beat, the queue fills and s_tready falls when full.
// ----------------------------------------------------------------------------
module utf8_sanitizer #(
    parameter int Q_DEPTH = utf8s_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // string_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_last
);

    utf8s_pkg::q_stat_t q_stat;
    utf8s_pkg::cmd_t    push_cmd;
    utf8s_pkg::cmd_t    head_cmd;
    logic               push;
    logic               pop;

    utf8s_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    utf8s_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    utf8s_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: test/tb_utf8_sanitizer.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer testbench
// Sends a short list of hand-picked bytes through the sanitizer, then random
// runs of mostly well-formed UTF-8 with broken and stray bytes mixed in. Both
// stream sides idle at random. A behavioural predictor of the sanitiser works
// out the output beats of every accepted byte, and each output beat is
// checked against the oldest one still waiting.
// ----------------------------------------------------------------------------
module tb_utf8_sanitizer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIR        = 25;
    localparam int RANDOM_ITEMS = 95;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int PREDICTED    = -1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // A directed row either types its output beats in (n_typed of them, taken
    // from typed, lowest byte first) or leaves them to the predictor.
    typedef struct packed {
        logic [7:0]      in_byte;
        logic            fin;
        int              n_typed;
        logic [2:0][7:0] typed;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{8'h00, 1'b0, 0,         '0},           // lowest control, dropped
        '{8'h20, 1'b0, 1,         {16'h0, 8'h20}},
        '{8'h7E, 1'b0, 1,         {16'h0, 8'h7E}},
        '{8'h7F, 1'b0, 0,         '0},           // DEL, dropped
        '{8'h80, 1'b0, 3,         utf8s_pkg::REPL_SEQ},     // stray continuation
        '{8'hC0, 1'b0, 3,         utf8s_pkg::REPL_SEQ},     // illegal lead
        '{8'hFF, 1'b1, 3,         utf8s_pkg::REPL_SEQ},
        '{8'hDF, 1'b0, PREDICTED, '0},
        '{8'hBF, 1'b0, PREDICTED, '0},
        '{8'hE0, 1'b0, PREDICTED, '0},
        '{8'h9F, 1'b0, PREDICTED, '0},           // overlong second byte
        '{8'hED, 1'b0, PREDICTED, '0},
        '{8'hA0, 1'b1, PREDICTED, '0},           // surrogate on the final byte
        '{8'hF0, 1'b0, PREDICTED, '0},
        '{8'h90, 1'b0, PREDICTED, '0},
        '{8'h80, 1'b1, PREDICTED, '0},           // cut short at string end
        '{8'hF4, 1'b0, PREDICTED, '0},
        '{8'h8F, 1'b0, PREDICTED, '0},
        '{8'hBF, 1'b0, PREDICTED, '0},
        '{8'hBF, 1'b0, PREDICTED, '0},
        '{8'hE1, 1'b1, 3,         utf8s_pkg::REPL_SEQ},     // lead carrying string end
        '{8'hF0, 1'b0, PREDICTED, '0},
        '{8'h90, 1'b0, PREDICTED, '0},
        '{8'h80, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b1, PREDICTED, '0}            // longest burst of output
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Predictor state: the sequence still waiting for continuation bytes.
    logic [7:0] pend_lead = 8'h00;
    logic [1:0] pend_need = 2'd0;
    logic [1:0] pend_seen = 2'd0;
    logic [7:0] pend_cont [3];

    logic [7:0] step_bytes [$];
    out_beat_t  sanitised_q [$];

    int error_count = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    bit no_idle     = 1'b0;
    bit drained_mid = 1'b0;

    utf8_sanitizer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, sanitised_q.size());
            $display("** utf8_sanitizer: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    function automatic int pick_gap();
        return no_idle ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        step_bytes = {step_bytes, b};
    endfunction

    function automatic void add_repl();
        int i;
        for (i = 0; i < 3; i++)
            append_byte(utf8s_pkg::REPL_SEQ[i]);
    endfunction

    // The pending lead and every continuation taken so far each become U+FFFD.
    function automatic void drop_pending();
        int i;
        for (i = 0; i <= int'(pend_seen); i++)
            add_repl();
        pend_need = 2'd0;
        pend_seen = 2'd0;
    endfunction

    function automatic void take_fresh(input logic [7:0] b, input logic fin);
        logic [1:0] need;
        if (b < utf8s_pkg::CONT_LO) begin
            if (b >= utf8s_pkg::PRINT_LO && b != utf8s_pkg::DEL_CHAR)
                append_byte(b);
            return;
        end
        if (b >= utf8s_pkg::LEAD2_LO && b <= utf8s_pkg::LEAD2_HI)
            need = 2'd1;
        else if (b >= utf8s_pkg::LEAD3_LO && b <= utf8s_pkg::LEAD3_HI)
            need = 2'd2;
        else if (b >= utf8s_pkg::LEAD4_LO && b <= utf8s_pkg::LEAD4_HI)
            need = 2'd3;
        else begin
            add_repl();
            return;
        end
        if (fin) begin
            add_repl();
        end else begin
            pend_lead = b;
            pend_need = need;
            pend_seen = 2'd0;
        end
    endfunction

    // Leaves in step_bytes the output bytes that one accepted input byte causes.
    function automatic void predict_step(input logic [7:0] b, input logic fin);
        logic ok;
        int   i;
        step_bytes.delete();
        if (pend_need == 2'd0) begin
            take_fresh(b, fin);
            return;
        end
        ok = (b >= utf8s_pkg::CONT_LO && b <= utf8s_pkg::CONT_HI);
        if (ok && pend_seen == 2'd0) begin
            case (pend_lead)
                utf8s_pkg::LEAD3_LO:  ok = (b >= utf8s_pkg::E0_MIN);
                utf8s_pkg::SURR_LEAD: ok = (b <= utf8s_pkg::SURR_MAX);
                utf8s_pkg::LEAD4_LO:  ok = (b >= utf8s_pkg::F0_MIN);
                utf8s_pkg::LEAD4_HI:  ok = (b <= utf8s_pkg::F4_MAX);
                default: ;
            endcase
        end
        if (ok) begin
            pend_cont[pend_seen] = b;
            pend_seen = pend_seen + 2'd1;
            if (pend_seen == pend_need) begin
                append_byte(pend_lead);
                for (i = 0; i < int'(pend_seen); i++)
                    append_byte(pend_cont[i]);
                pend_need = 2'd0;
                pend_seen = 2'd0;
            end else if (fin) begin
                drop_pending();
            end
        end else begin
            drop_pending();
            take_fresh(b, fin);
        end
    endfunction

    // Valid stays high from one beat to the next when no gap is drawn.
    task automatic send_beat(input logic [7:0] b, input logic fin, input int n_typed,
                             input logic [2:0][7:0] typed);
        int        gap;
        int        i;
        out_beat_t beat;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_step(b, fin);
        if (n_typed == PREDICTED) begin
            for (i = 0; i < step_bytes.size(); i++) begin
                beat.data = step_bytes[i];
                beat.last = (i == step_bytes.size() - 1);
                sanitised_q = {sanitised_q, beat};
            end
        end else begin
            for (i = 0; i < n_typed; i++) begin
                beat.data = typed[i];
                beat.last = (i == n_typed - 1);
                sanitised_q = {sanitised_q, beat};
            end
        end
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (sanitised_q.size() != 0) @(posedge aclk);
    endtask

    // One character's worth of bytes: mostly well-formed sequences, some
    // random noise and some sequences with one continuation overwritten.
    task automatic send_random_run();
        logic [7:0] seq [4];
        int         len;
        int         kind;
        int         i;
        logic       fin;
        kind   = int'($urandom_range(0, 9));
        len    = 1;
        seq[0] = 8'($urandom_range(0, 8'h7F));
        if (kind == 8) begin
            seq[0] = 8'($urandom_range(0, 255));
        end else if (kind >= 2) begin
            len = (kind == 9) ? int'($urandom_range(2, 4)) : kind / 2 + 1;
            case (len)
                2: seq[0] = 8'($urandom_range(utf8s_pkg::LEAD2_LO, utf8s_pkg::LEAD2_HI));
                3: begin
                    if ($urandom_range(0, 1) == 0)
                        seq[0] = $urandom_range(0, 1) ? utf8s_pkg::LEAD3_LO
                                                      : utf8s_pkg::SURR_LEAD;
                    else
                        seq[0] = 8'($urandom_range(utf8s_pkg::LEAD3_LO,
                                                   utf8s_pkg::LEAD3_HI));
                end
                default: seq[0] = 8'($urandom_range(utf8s_pkg::LEAD4_LO,
                                                    utf8s_pkg::LEAD4_HI));
            endcase
            for (i = 1; i < len; i++)
                seq[i] = 8'($urandom_range(utf8s_pkg::CONT_LO, utf8s_pkg::CONT_HI));
            case (seq[0])
                utf8s_pkg::LEAD3_LO:
                    seq[1] = 8'($urandom_range(utf8s_pkg::E0_MIN, utf8s_pkg::CONT_HI));
                utf8s_pkg::SURR_LEAD:
                    seq[1] = 8'($urandom_range(utf8s_pkg::CONT_LO, utf8s_pkg::SURR_MAX));
                utf8s_pkg::LEAD4_LO:
                    seq[1] = 8'($urandom_range(utf8s_pkg::F0_MIN, utf8s_pkg::CONT_HI));
                utf8s_pkg::LEAD4_HI:
                    seq[1] = 8'($urandom_range(utf8s_pkg::CONT_LO, utf8s_pkg::F4_MAX));
                default: ;
            endcase
            if (kind == 9)
                seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end
        for (i = 0; i < len; i++) begin
            if (i == len - 1)
                fin = ($urandom_range(0, 3) == 0);
            else
                fin = ($urandom_range(0, 11) == 0);
            send_beat(seq[i], fin, PREDICTED, '0);
        end
    endtask

    // Output side: random stalls before every beat, then a check against the
    // oldest expected beat.
    initial begin
        int        gap;
        out_beat_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (sanitised_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat data %02h last %0b",
                                          m_tdata, m_tlast));
            end else begin
                want = sanitised_q.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("data %02h, expected %02h",
                                              m_tdata, want.data));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b on data %02h",
                                              m_tlast, want.last, want.data));
            end
        end
    end

    initial begin
        int i;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_DIR; i++)
            send_beat(DIR_ROWS[i].in_byte, DIR_ROWS[i].fin, DIR_ROWS[i].n_typed,
                      DIR_ROWS[i].typed);
        wait_for_drain();

        while (items_sent < N_DIR + RANDOM_ITEMS) begin
            // Stretches of back-to-back beats on both sides between idling ones.
            no_idle = ((items_sent - N_DIR) % 40) >= 25;
            send_random_run();
            if (!drained_mid && items_sent >= N_DIR + RANDOM_ITEMS / 2) begin
                wait_for_drain();
                drained_mid = 1'b1;
            end
        end
        wait_for_drain();
        repeat (20) @(posedge aclk);

        if (error_count == 0)
            $display("** utf8_sanitizer: PASSED **");
        else
            $display("** utf8_sanitizer: FAILED **");
        $finish;
    end

endmodule

FILE: utf8_sanitizer.f
+incdir+design
design/utf8s_pkg.sv
design/utf8s_front.sv
design/utf8s_queue.sv
design/utf8s_back.sv
design/utf8_sanitizer.sv
test/tb_utf8_sanitizer.sv
